>>> sv/assert_macros.svh
// Assertion macros shared by the parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Condition must never be seen
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> sv/ochp_pkg.sv
// Types and constants of the out-of-band hex command parser
`default_nettype none

package ochp_pkg;

    // Sizes of the decoded byte store
    localparam int MAX_DECODED_BYTES = 39;
    localparam int IDX_W             = $clog2(MAX_DECODED_BYTES);
    localparam int CNT_W             = $clog2(MAX_DECODED_BYTES + 1);
    localparam int RAM_AW            = IDX_W + 1;
    localparam int RAM_DEPTH         = 2 ** RAM_AW;

    // Peer load byte counts
    localparam int LOAD_COUNT   = 32;
    localparam int LONG_COUNT   = 39;
    localparam int LONG_SKIP    = 7;
    localparam int BYTE_INDEX_W = 5;

    // Line-end job queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_NONE   = 3'd0,
        ST_LOCAL  = 3'd1,
        ST_LOADED = 3'd2,
        ST_FORMAT = 3'd3,
        ST_USAGE  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_SKIP,
        PH_PEER,
        PH_HEX,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_line;
    } t_in_item;

    typedef struct packed {
        t_status                 status;
        logic [7:0]              peer_byte;
        logic [BYTE_INDEX_W-1:0] byte_index;
        logic                    last;
    } t_out_item;

    // One finished line, as handed from front to back
    typedef struct packed {
        t_status status;
        logic    bank;
        logic    skip_lead;
    } t_job;

    // Store write port from the front
    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    // Bank handed back once its bytes are all read
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage

`default_nettype wire

>>> sv/ochp_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module ochp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/ochp_front.sv
// Front end: classifies command bytes, decodes hex into the store, queues line results
`default_nettype none
`include "assert_macros.svh"

module ochp_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire ochp_pkg::t_in_item i_in_item,
    output logic                  o_in_stall,
    output ochp_pkg::t_wr         o_wr,
    output logic                  o_push,
    output ochp_pkg::t_job        o_job,
    input  wire logic             i_q_full,
    input  wire ochp_pkg::t_release i_release
);

    import ochp_pkg::*;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    // "oob" and "peer", first letter in element 0
    localparam logic [2:0][7:0] WORD_CMD  = {8'h62, 8'h6F, 8'h6F};
    localparam logic [3:0][7:0] WORD_PEER = {8'h72, 8'h65, 8'h65, 8'h70};

    function automatic logic hex_ok(input logic [7:0] c);
        hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
              || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c <= 8'h39) begin
            hex_nibble = c[3:0];
        end else begin
            hex_nibble = c[3:0] + 4'd9;
        end
    endfunction

    t_phase           r_phase, s_phase, n_phase;
    logic [2:0]       r_match, s_match, n_match;
    logic             r_nib_valid, s_nib_valid, n_nib_valid;
    logic [3:0]       r_nib, s_nib, n_nib;
    logic [CNT_W-1:0] r_count, s_count, n_count;
    t_status          r_outcome, s_outcome, n_outcome;
    logic             r_bank, n_bank;
    logic [1:0]       r_busy, n_busy;

    logic [7:0] c;
    logic       accept;
    logic       eol;
    logic       is_blank;
    logic       is_crlf;
    logic       is_sep;
    logic       is_hex;
    logic       cmd_hit;
    logic       peer_hit;
    logic       store_full;
    t_status    end_status;
    logic       end_skip;

    assign c          = i_in_item.text_byte;
    assign eol        = i_in_item.end_of_line;
    assign o_in_stall = i_q_full || r_busy[r_bank];
    assign accept     = i_in_valid && !o_in_stall;

    // Classify the byte
    assign is_blank   = (c == CH_SPACE) || (c == CH_TAB);
    assign is_crlf    = (c == CH_CR) || (c == CH_LF);
    assign is_sep     = is_blank || is_crlf || (c == CH_COLON) || (c == CH_DASH);
    assign is_hex     = hex_ok(c);
    assign cmd_hit    = (r_match < 3'd3) && (c == WORD_CMD[r_match[1:0]]);
    assign peer_hit   = (r_match < 3'd4) && (c == WORD_PEER[r_match[1:0]]);
    assign store_full = r_count >= CNT_W'(MAX_DECODED_BYTES);

    // Phase after this byte
    always_comb begin
        s_phase = r_phase;
        unique case (r_phase)
            PH_PREFIX: begin
                if (!cmd_hit) begin
                    s_phase = PH_DONE;
                end else if (r_match == 3'd2) begin
                    s_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (is_blank) begin
                    s_phase = PH_SKIP;
                end else if (!is_crlf && c == WORD_PEER[0]) begin
                    s_phase = PH_PEER;
                end else begin
                    s_phase = PH_DONE;
                end
            end
            PH_PEER: begin
                if (!peer_hit) begin
                    s_phase = PH_DONE;
                end else if (r_match == 3'd3) begin
                    s_phase = PH_HEX;
                end
            end
            PH_HEX: begin
                if (!is_hex && !is_sep) begin
                    s_phase = PH_DONE;
                end else if (is_hex && r_nib_valid && store_full) begin
                    s_phase = PH_DONE;
                end
            end
            PH_DONE: s_phase = PH_DONE;
            default: s_phase = PH_DONE;
        endcase
    end

    // Match position, nibble, count, outcome and store write after this byte
    always_comb begin
        s_match     = r_match;
        s_nib_valid = r_nib_valid;
        s_nib       = r_nib;
        s_count     = r_count;
        s_outcome   = r_outcome;
        o_wr.en     = 1'b0;
        o_wr.addr   = {r_bank, r_count[IDX_W-1:0]};
        o_wr.data   = {r_nib, hex_nibble(c)};
        unique case (r_phase)
            PH_PREFIX: begin
                if (!cmd_hit) begin
                    s_outcome = ST_NONE;
                end else if (r_match == 3'd2) begin
                    s_match = 3'd0;
                end else begin
                    s_match = r_match + 3'd1;
                end
            end
            PH_SKIP: begin
                if (is_blank) begin
                    s_match = r_match;
                end else if (is_crlf) begin
                    s_outcome = ST_LOCAL;
                end else if (c == WORD_PEER[0]) begin
                    s_match = 3'd1;
                end else begin
                    s_outcome = ST_USAGE;
                end
            end
            PH_PEER: begin
                if (!peer_hit) begin
                    s_outcome = ST_USAGE;
                end else if (r_match == 3'd3) begin
                    s_match = 3'd0;
                end else begin
                    s_match = r_match + 3'd1;
                end
            end
            PH_HEX: begin
                if (!is_hex) begin
                    if (!is_sep) begin
                        s_outcome = ST_FORMAT;
                    end
                end else if (!r_nib_valid) begin
                    s_nib_valid = 1'b1;
                    s_nib       = hex_nibble(c);
                end else if (store_full) begin
                    s_outcome = ST_FORMAT;
                end else begin
                    o_wr.en     = accept;
                    s_count     = r_count + CNT_W'(1);
                    s_nib_valid = 1'b0;
                    s_nib       = 4'd0;
                end
            end
            PH_DONE: s_outcome = r_outcome;
            default: s_outcome = r_outcome;
        endcase
    end

    // Line result at end of line
    always_comb begin
        end_status = s_outcome;
        end_skip   = 1'b0;
        unique case (s_phase)
            PH_PREFIX: end_status = ST_NONE;
            PH_SKIP:   end_status = ST_LOCAL;
            PH_PEER:   end_status = ST_USAGE;
            PH_HEX: begin
                if (s_nib_valid) begin
                    end_status = ST_FORMAT;
                end else if (s_count == CNT_W'(LOAD_COUNT)) begin
                    end_status = ST_LOADED;
                end else if (s_count == CNT_W'(LONG_COUNT)) begin
                    end_status = ST_LOADED;
                    end_skip   = 1'b1;
                end else begin
                    end_status = ST_FORMAT;
                end
            end
            PH_DONE:   end_status = s_outcome;
            default:   end_status = s_outcome;
        endcase
    end

    assign o_push        = accept && eol;
    assign o_job.status  = end_status;
    assign o_job.bank    = r_bank;
    assign o_job.skip_lead = end_skip;

    // Clear line state at end of line, flip bank after a load
    always_comb begin
        n_phase     = r_phase;
        n_match     = r_match;
        n_nib_valid = r_nib_valid;
        n_nib       = r_nib;
        n_count     = r_count;
        n_outcome   = r_outcome;
        n_bank      = r_bank;
        n_busy      = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (accept) begin
            if (eol) begin
                n_phase     = PH_PREFIX;
                n_match     = 3'd0;
                n_nib_valid = 1'b0;
                n_nib       = 4'd0;
                n_count     = '0;
                n_outcome   = ST_NONE;
                if (end_status == ST_LOADED) begin
                    n_busy[r_bank] = 1'b1;
                    n_bank         = !r_bank;
                end
            end else begin
                n_phase     = s_phase;
                n_match     = s_match;
                n_nib_valid = s_nib_valid;
                n_nib       = s_nib;
                n_count     = s_count;
                n_outcome   = s_outcome;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PREFIX;
            r_match     <= 3'd0;
            r_nib_valid <= 1'b0;
            r_nib       <= 4'd0;
            r_count     <= '0;
            r_outcome   <= ST_NONE;
            r_bank      <= 1'b0;
            r_busy      <= 2'b00;
        end else begin
            r_phase     <= n_phase;
            r_match     <= n_match;
            r_nib_valid <= n_nib_valid;
            r_nib       <= n_nib;
            r_count     <= n_count;
            r_outcome   <= n_outcome;
            r_bank      <= n_bank;
            r_busy      <= n_busy;
        end
    end

    `ASSERT_NEVER(a_wr_busy_bank, i_clk, i_rst_n, o_wr.en && r_busy[r_bank])
    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(MAX_DECODED_BYTES))
    `ASSERT_NEXT(a_bank_flip, i_clk, i_rst_n, o_push && o_job.status == ST_LOADED, r_bank != $past(r_bank))

endmodule

`default_nettype wire

>>> sv/ochp_queue.sv
// Short queue of finished lines between front and back
`default_nettype none

module ochp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ochp_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_head_valid,
    output ochp_pkg::t_job      o_head
);

    import ochp_pkg::*;

    t_job              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full       = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_head_valid = r_count != '0;
    assign o_head       = r_entry[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

>>> sv/ochp_back.sv
// Back end: expands queued line results into output transfers, reading the store
`default_nettype none
`include "assert_macros.svh"

module ochp_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_head_valid,
    input  wire ochp_pkg::t_job     i_head,
    output logic                    o_pop,
    output ochp_pkg::t_release      o_release,
    output logic                    o_rd_en,
    output logic [ochp_pkg::RAM_AW-1:0] o_rd_addr,
    input  wire logic [7:0]         i_rd_data,
    output logic                    o_out_valid,
    output ochp_pkg::t_out_item     o_out_item,
    input  wire logic               i_out_stall
);

    import ochp_pkg::*;

    localparam logic [BYTE_INDEX_W-1:0] LAST_INDEX = BYTE_INDEX_W'(LOAD_COUNT - 1);

    typedef struct packed {
        t_status                 status;
        logic [BYTE_INDEX_W-1:0] index;
        logic                    last;
        logic                    from_ram;
    } t_stage;

    logic [BYTE_INDEX_W-1:0] r_k, n_k;
    logic                    r_s1_valid, n_s1_valid;
    t_stage                  r_s1;
    logic                    n_o_valid;
    logic                    s2_ready;
    logic                    s1_adv;
    logic                    s1_load;
    logic                    is_loaded;
    logic                    last_read;
    logic [IDX_W-1:0]        rd_idx;

    assign s2_ready  = !o_out_valid || !i_out_stall;
    assign s1_adv    = r_s1_valid && s2_ready;
    assign s1_load   = i_head_valid && (!r_s1_valid || s2_ready);
    assign is_loaded = i_head.status == ST_LOADED;
    assign last_read = !is_loaded || (r_k == LAST_INDEX);

    // Read address: byte k, offset past the leading bytes of a long load
    assign rd_idx    = IDX_W'(r_k) + (i_head.skip_lead ? IDX_W'(LONG_SKIP) : '0);
    assign o_rd_en   = s1_load && is_loaded;
    assign o_rd_addr = {i_head.bank, rd_idx};

    assign o_pop           = s1_load && last_read;
    assign o_release.valid = s1_load && is_loaded && last_read;
    assign o_release.bank  = i_head.bank;

    // Step through the bytes of the head job
    always_comb begin
        n_k = r_k;
        if (s1_load && is_loaded) begin
            n_k = last_read ? '0 : r_k + BYTE_INDEX_W'(1);
        end
        n_s1_valid = r_s1_valid;
        if (s1_load) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_o_valid = o_out_valid;
        if (s1_adv) begin
            n_o_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_s1_valid  <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_k         <= n_k;
            r_s1_valid  <= n_s1_valid;
            o_out_valid <= n_o_valid;
        end
    end

    // Read stage: hold metadata alongside the store read
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1.status   <= i_head.status;
            r_s1.index    <= is_loaded ? r_k : '0;
            r_s1.last     <= last_read;
            r_s1.from_ram <= is_loaded;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            o_out_item.status     <= r_s1.status;
            o_out_item.peer_byte  <= r_s1.from_ram ? i_rd_data : 8'd0;
            o_out_item.byte_index <= r_s1.index;
            o_out_item.last       <= r_s1.last;
        end
    end

    `ASSERT_IMPLIES(a_k_in_load, i_clk, i_rst_n, r_k != '0, i_head_valid && i_head.status == ST_LOADED)
    `ASSERT_IMPLIES(a_last_index, i_clk, i_rst_n, r_s1_valid && r_s1.from_ram && r_s1.last, r_s1.index == LAST_INDEX)
    `ASSERT_IMPLIES(a_hold_on_stall, i_clk, i_rst_n, o_out_valid && i_out_stall, !s1_adv)

endmodule

`default_nettype wire

>>> sv/oob_hex_command_parser_core.sv
// Top level of the out-of-band hex command parser
`default_nettype none

// Takes one console byte per cycle unless stalled and answers at each end-of-line byte.
// A line that does not start with "oob" gives one result with status 0; "oob" alone or
// followed by CR/LF gives show local, an unknown word gives usage, and "oob peer"
// followed by hex pairs gives either a format error or 32 results carrying the 16 r
// and 16 c bytes (with 39 bytes the first 7 are dropped). Every result has last set on
// the final one of its line. Results pass through the queue, the read stage and the
// output register and leave at one per cycle while the output is not stalled. Decoded
// bytes go into a two-bank store, one bank per line, so a new line decodes while the
// previous load is read out. Input stalls only when the bank it would fill is still
// being read out, or when two finished lines already wait for the output side.
module oob_hex_command_parser_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire ochp_pkg::t_in_item  i_in_item,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output ochp_pkg::t_out_item      o_out_item,
    input  wire logic                i_out_stall
);

    import ochp_pkg::*;

    t_wr               wr;
    logic              push;
    t_job              job;
    logic              q_full;
    logic              pop;
    logic              head_valid;
    t_job              head;
    t_release          release_bank;
    logic              rd_en;
    logic [RAM_AW-1:0] rd_addr;
    logic [7:0]        rd_data;

    // Byte classifier and hex decoder
    ochp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .o_wr       (wr),
        .o_push     (push),
        .o_job      (job),
        .i_q_full   (q_full),
        .i_release  (release_bank)
    );

    // Finished lines awaiting output
    ochp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // Decoded byte store, two banks
    ochp_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr.en),
        .i_wr_addr (wr.addr),
        .i_wr_data (wr.data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Result sequencer
    ochp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_release    (release_bank),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item),
        .i_out_stall  (i_out_stall)
    );

endmodule

`default_nettype wire
